// ----- hdl/mrrim_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrim_pkg
// Shared codes, constants and the CRC-16 byte step for the Modbus RTU
// read-input-registers master.
// ----------------------------------------------------------------------------
package mrrim_pkg;

  // Input actions, carried on the slave-side tuser.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Result kinds, carried on the master-side tuser.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Transaction status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SLAVE = 3'd1;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd2;
  localparam logic [2:0] ST_EXCEPTION = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;
  localparam logic [2:0] ST_BAD_CRC   = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  FUNC_MASK       = 8'h7F;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] READ_OOB_VALUE  = 16'hFFFF;
  localparam logic [7:0]  SLAVE_RESET     = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd2000;

  // One byte of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/mrrim_ram.sv -----
// ----------------------------------------------------------------------------
// mrrim_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module mrrim_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/modbus_rtu_read_input_master.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_read_input_master
// Modbus RTU master for Read Input Registers (function 0x04).
// ----------------------------------------------------------------------------
// Each item is taken into an input register; a byte, tick or read item can
// be taken every cycle while no result waits. A start item emits eight
// transmit words, one per cycle while the output is ready, from the result
// register, which builds the request CRC one byte per output word; an item
// that gives a result waits while they drain, and a byte or tick item that
// gives none goes on. A read item's value reaches the output from the word
// RAM's registered port. Reply words are staged in the bank opposite to each
// entry's committed copy, and a good CRC flips those entries' bank bits at once.
module modbus_rtu_read_input_master #(
  parameter int WORD_STORE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: start_register[15:0], register_quantity[23:16], rx_data[31:24],
  // word_index[39:32]
  input  logic [39:0] s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: tx_data[7:0], status[10:8], exception_code[18:11],
  // word_count[25:19], read_value[41:26], zero fill[47:42]
  output logic [47:0] m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int D  = WORD_STORE_DEPTH;
  localparam int IW = (D > 1) ? $clog2(D) : 1;
  localparam int RD = 2 * D;
  localparam int AW = $clog2(RD);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_RECV = 1'b1;

  // Configuration registers.
  logic [7:0]  slave_addr_q;
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= mrrim_pkg::SLAVE_RESET;
      timeout_q    <= mrrim_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == mrrim_pkg::CFG_SLAVE_ADDRESS) begin
        slave_addr_q <= cfg_wdata_i[7:0];
      end else begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Input register.
  logic        p_valid_q;
  logic [1:0]  p_action_q;
  logic [15:0] p_reg_q;
  logic [7:0]  p_qty_q;
  logic [7:0]  p_rx_q;
  logic [7:0]  p_idx_q;
  logic        p_adv;

  assign s_axis_tready = !p_valid_q || p_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      p_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      p_action_q <= s_axis_tuser;
      p_reg_q    <= s_axis_tdata[15:0];
      p_qty_q    <= s_axis_tdata[23:16];
      p_rx_q     <= s_axis_tdata[31:24];
      p_idx_q    <= s_axis_tdata[39:32];
    end
  end

  // Reply state.
  logic         phase_q, phase_d;
  logic [7:0]   br_q, br_d;
  logic [7:0]   rem_q, rem_d;
  logic [15:0]  crc_q, crc_d;
  logic [7:0]   func_q, func_d;
  logic [7:0]   bcnt_q, bcnt_d;
  logic [7:0]   pend_q, pend_d;
  logic [15:0]  elapsed_q, elapsed_d;
  logic         slave_bad_q, slave_bad_d;
  logic [D-1:0] sel_q, sel_d;

  // Result register.
  logic        r_valid_q;
  logic [1:0]  r_kind_q;
  logic [2:0]  r_beat_q;
  logic [7:0]  r_slave_q;
  logic [15:0] r_reg_q;
  logic [7:0]  r_qty_q;
  logic [15:0] r_crc_q;
  logic [2:0]  r_status_q;
  logic [7:0]  r_exc_q;
  logic [6:0]  r_wc_q;
  logic        r_oob_q;
  logic        r_last;
  logic        r_done;
  logic        r_free;

  // Item handling.
  logic          res;
  logic [2:0]    res_status;
  logic [7:0]    res_exc;
  logic [6:0]    res_wc;
  logic          stage_we;
  logic [8:0]    stage_i;
  logic [IW-1:0] stage_ix;
  logic [7:0]    stage_lo;
  logic [15:0]   crc_nx;
  logic [8:0]    k;
  logic          close;
  logic [7:0]    m;
  logic          rd_in;
  logic [IW-1:0] rd_ix;

  always_comb begin
    phase_d     = phase_q;
    br_d        = br_q;
    rem_d       = rem_q;
    crc_d       = crc_q;
    func_d      = func_q;
    bcnt_d      = bcnt_q;
    pend_d      = pend_q;
    elapsed_d   = elapsed_q;
    slave_bad_d = slave_bad_q;
    sel_d       = sel_q;
    res         = 1'b0;
    res_status  = mrrim_pkg::ST_OK;
    res_exc     = 8'h00;
    res_wc      = 7'd0;
    stage_we    = 1'b0;
    stage_i     = 9'd0;
    stage_lo    = p_rx_q;
    close       = 1'b0;
    crc_nx      = mrrim_pkg::crc_byte(crc_q, p_rx_q);
    k           = 9'(bcnt_q) + 9'd2 - 9'(rem_q);
    m           = ({1'b0, bcnt_q[7:1]} < 8'(D)) ? {1'b0, bcnt_q[7:1]} : 8'(D);
    rd_in       = (9'(p_idx_q) < 9'(D));
    case (p_action_q)
      mrrim_pkg::ACT_START: begin
        res         = 1'b1;
        phase_d     = PH_RECV;
        br_d        = 8'd0;
        rem_d       = 8'd9;
        crc_d       = mrrim_pkg::CRC_INIT;
        func_d      = 8'h00;
        bcnt_d      = 8'h00;
        pend_d      = 8'h00;
        elapsed_d   = 16'd0;
        slave_bad_d = 1'b0;
      end
      mrrim_pkg::ACT_BYTE: begin
        if (phase_q == PH_RECV && !(br_q == 8'd0 && p_rx_q == 8'd0)) begin
          crc_d = crc_nx;
          br_d  = (br_q == 8'hFF) ? br_q : br_q + 8'd1;
          case (br_q)
            8'd0: slave_bad_d = (p_rx_q != slave_addr_q);
            8'd1: func_d = p_rx_q;
            8'd2: bcnt_d = p_rx_q;
            8'd3: pend_d = p_rx_q;
            8'd4: begin
              if (slave_bad_q) begin
                res        = 1'b1;
                res_status = mrrim_pkg::ST_BAD_SLAVE;
              end else if ((func_q & mrrim_pkg::FUNC_MASK) != mrrim_pkg::FUNC_READ_INPUT) begin
                res        = 1'b1;
                res_status = mrrim_pkg::ST_BAD_FUNC;
              end else if (func_q[7]) begin
                res        = 1'b1;
                res_status = mrrim_pkg::ST_EXCEPTION;
                res_exc    = bcnt_q;
              end else begin
                stage_we = 1'b1;
                stage_i  = 9'd0;
                rem_d    = bcnt_q;
                close    = (bcnt_q == 8'd0);
              end
            end
            default: begin
              if (rem_q != 8'd0) begin
                if (k[0]) begin
                  stage_we = 1'b1;
                  stage_i  = {1'b0, k[8:1]};
                end else begin
                  pend_d = p_rx_q;
                end
                rem_d = rem_q - 8'd1;
                close = (rem_q == 8'd1);
              end
            end
          endcase
          // Closing a reply: commit the staged words when the residue is zero.
          if (close) begin
            res = 1'b1;
            if (crc_nx != 16'd0) begin
              res_status = mrrim_pkg::ST_BAD_CRC;
            end else begin
              res_wc = bcnt_q[7:1];
              for (int j = 0; j < D; j++) begin
                if (8'(j) < m) begin
                  sel_d[j] = ~sel_q[j];
                end
              end
            end
          end
          if (res) begin
            phase_d = PH_IDLE;
          end
        end
      end
      mrrim_pkg::ACT_TICK: begin
        if (phase_q == PH_RECV) begin
          if (elapsed_q >= timeout_q) begin
            res        = 1'b1;
            res_status = mrrim_pkg::ST_TIMEOUT;
            phase_d    = PH_IDLE;
          end else begin
            elapsed_d = elapsed_q + 16'd1;
          end
        end
      end
      default: begin
        res = 1'b1;
      end
    endcase
    // Words past the reply's count or past the store are dropped.
    if (stage_we && !(stage_i < {2'b00, bcnt_q[7:1]} && stage_i < 9'(D))) begin
      stage_we = 1'b0;
    end
  end

  assign stage_ix = stage_i[IW-1:0];
  assign rd_ix    = p_idx_q[IW-1:0];
  assign p_adv    = p_valid_q && (!res || r_free);

  // State update on each handled item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      br_q        <= 8'd0;
      rem_q       <= 8'd0;
      crc_q       <= mrrim_pkg::CRC_INIT;
      func_q      <= 8'd0;
      bcnt_q      <= 8'd0;
      pend_q      <= 8'd0;
      elapsed_q   <= 16'd0;
      slave_bad_q <= 1'b0;
      sel_q       <= '0;
    end else if (p_adv) begin
      phase_q     <= phase_d;
      br_q        <= br_d;
      rem_q       <= rem_d;
      crc_q       <= crc_d;
      func_q      <= func_d;
      bcnt_q      <= bcnt_d;
      pend_q      <= pend_d;
      elapsed_q   <= elapsed_d;
      slave_bad_q <= slave_bad_d;
      sel_q       <= sel_d;
    end
  end

  // Word store: two banks, each entry's committed bank chosen by sel_q.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_rdata;

  assign ram_we    = p_adv && stage_we;
  assign ram_waddr = (sel_q[stage_ix] ? AW'(0) : AW'(D)) + AW'(stage_ix);
  assign ram_re    = p_adv && (p_action_q == mrrim_pkg::ACT_READ) && rd_in;
  assign ram_raddr = (sel_q[rd_ix] ? AW'(D) : AW'(0)) + AW'(rd_ix);

  mrrim_ram #(
    .WIDTH (16),
    .DEPTH (RD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({pend_q, stage_lo}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register and request sequencing.
  logic [7:0] tx_byte;

  assign r_last = (r_kind_q != mrrim_pkg::KIND_TX) || (r_beat_q == 3'd7);
  assign r_done = r_valid_q && m_axis_tready && r_last;
  assign r_free = !r_valid_q || r_done;

  always_comb begin
    case (r_beat_q)
      3'd0:    tx_byte = r_slave_q;
      3'd1:    tx_byte = mrrim_pkg::FUNC_READ_INPUT;
      3'd2:    tx_byte = r_reg_q[15:8];
      3'd3:    tx_byte = r_reg_q[7:0];
      3'd4:    tx_byte = 8'h00;
      3'd5:    tx_byte = r_qty_q;
      3'd6:    tx_byte = r_crc_q[7:0];
      default: tx_byte = r_crc_q[15:8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      r_beat_q  <= 3'd0;
      r_kind_q  <= mrrim_pkg::KIND_TX;
    end else if (p_adv && res) begin
      r_valid_q <= 1'b1;
      r_beat_q  <= 3'd0;
      case (p_action_q)
        mrrim_pkg::ACT_START: r_kind_q <= mrrim_pkg::KIND_TX;
        mrrim_pkg::ACT_READ:  r_kind_q <= mrrim_pkg::KIND_READ;
        default:              r_kind_q <= mrrim_pkg::KIND_STATUS;
      endcase
    end else if (r_done) begin
      r_valid_q <= 1'b0;
    end else if (r_valid_q && m_axis_tready) begin
      r_beat_q <= r_beat_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv && res) begin
      r_slave_q  <= slave_addr_q;
      r_reg_q    <= p_reg_q;
      r_qty_q    <= p_qty_q;
      r_crc_q    <= mrrim_pkg::CRC_INIT;
      r_status_q <= res_status;
      r_exc_q    <= res_exc;
      r_wc_q     <= res_wc;
      r_oob_q    <= !rd_in;
    end else if (r_valid_q && m_axis_tready && r_beat_q < 3'd6) begin
      r_crc_q <= mrrim_pkg::crc_byte(r_crc_q, tx_byte);
    end
  end

  // Output word.
  logic is_tx, is_st, is_rd;
  logic [15:0] rd_value;

  assign is_tx    = (r_kind_q == mrrim_pkg::KIND_TX);
  assign is_st    = (r_kind_q == mrrim_pkg::KIND_STATUS);
  assign is_rd    = (r_kind_q == mrrim_pkg::KIND_READ);
  assign rd_value = r_oob_q ? mrrim_pkg::READ_OOB_VALUE : ram_rdata;

  assign m_axis_tvalid = r_valid_q;
  assign m_axis_tuser  = r_kind_q;
  assign m_axis_tlast  = is_tx && (r_beat_q == 3'd7);
  assign m_axis_tdata  = {6'd0,
                          is_rd ? rd_value : 16'd0,
                          is_st ? r_wc_q : 7'd0,
                          is_st ? r_exc_q : 8'd0,
                          is_st ? r_status_q : 3'd0,
                          is_tx ? tx_byte : 8'd0};

`ifndef ASSERT_OFF
  // The last flag only ever closes a request.
  a_last_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tlast |-> (m_axis_tuser == mrrim_pkg::KIND_TX))
    else $error("tlast on a non-transmit word");

  // Request words step through their beats one at a time.
  a_beat_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && m_axis_tready && !r_last) |=> (r_beat_q == $past(r_beat_q) + 3'd1))
    else $error("request beat skipped");

  // A held item is neither lost nor altered.
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !p_adv) |=> (p_valid_q && $stable(p_action_q) && $stable(p_rx_q)))
    else $error("stalled item changed");

  // No new result is loaded while a result is still waiting.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_adv && res) |-> r_free)
    else $error("result register overrun");
`endif

endmodule

// ----- tb/sv/modbus_rtu_read_input_master_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_read_input_master_tb
// Self-checking bench for the Modbus RTU read-input-registers master. It
// drives start, received-byte, tick and read words with random gaps, runs
// a behavioral model of the master in parallel, and compares every result
// word field by field. It covers well-formed replies with good and bad CRC,
// exceptions, bad slave and bad function replies, timeouts, and reads.
// ----------------------------------------------------------------------------
module modbus_rtu_read_input_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_data;
    logic        last;
    logic [2:0]  status;
    logic [7:0]  exc_code;
    logic [6:0]  word_count;
    logic [15:0] read_value;
  } result_t;

  // Scoreboard: holds the expected result words and checks arrivals.
  class master_scoreboard;
    result_t expected_q[$];
    int      errors;

    function void note_input(result_t r);
      expected_q.push_back(r);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] exp);
      $display("MISMATCH %s: got %0h expected %0h", what, got, exp);
      errors++;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        report("unexpected word", 64'(got), 64'd0);
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind != exp.kind) report("kind", 64'(got.kind), 64'(exp.kind));
      if (got.tx_data != exp.tx_data)
        report("tx_data", 64'(got.tx_data), 64'(exp.tx_data));
      if (got.last != exp.last) report("last", 64'(got.last), 64'(exp.last));
      if (got.status != exp.status)
        report("status", 64'(got.status), 64'(exp.status));
      if (got.exc_code != exp.exc_code)
        report("exception", 64'(got.exc_code), 64'(exp.exc_code));
      if (got.word_count != exp.word_count)
        report("word_count", 64'(got.word_count), 64'(exp.word_count));
      if (got.read_value != exp.read_value)
        report("read_value", 64'(got.read_value), 64'(exp.read_value));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  modbus_rtu_read_input_master #(.WORD_STORE_DEPTH(DEPTH)) DUT (.*);

  master_scoreboard sb = new();

  // Model state of the master.
  logic [7:0]  m_slave = mrrim_pkg::SLAVE_RESET;
  logic [15:0] m_timeout = mrrim_pkg::TIMEOUT_RESET;
  logic        m_receiving;
  logic [7:0]  m_rx_count, m_remaining, m_func, m_byte_count, m_high;
  logic [15:0] m_crc, m_ticks;
  logic        m_slave_bad;
  logic [15:0] store_words [DEPTH];
  logic [15:0] staged_words [DEPTH];
  logic        store_written [DEPTH];
  int          store_count;

  bit no_idle = 0;
  bit idle_rx = 1;

  initial forever #4 clk_i = ~clk_i;

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    c ^= {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic result_t status_word(logic [2:0] st, logic [7:0] ex, logic [6:0] wc);
    result_t r;
    r = '0;
    r.kind = mrrim_pkg::KIND_STATUS;
    r.status = st;
    r.exc_code = ex;
    r.word_count = wc;
    m_receiving = 1'b0;
    return r;
  endfunction

  function automatic void stage(int i, logic [7:0] lo);
    if (i < (m_byte_count >> 1) && i < DEPTH) staged_words[i] = {m_high, lo};
  endfunction

  function automatic void close_reply();
    int words, n;
    if (m_crc != 16'h0) begin
      sb.note_input(status_word(mrrim_pkg::ST_BAD_CRC, 8'h00, 7'd0));
      return;
    end
    words = m_byte_count >> 1;
    n = words < DEPTH ? words : DEPTH;
    for (int i = 0; i < n; i++) begin
      store_words[i] = staged_words[i];
      store_written[i] = 1'b1;
    end
    sb.note_input(status_word(mrrim_pkg::ST_OK, 8'h00, 7'(words)));
  endfunction

  // Predicts the result words of one accepted input word.
  function automatic void predict_master(logic [1:0] act, logic [39:0] d);
    result_t r;
    logic [7:0] req [8];
    logic [15:0] c;
    logic [7:0] b, n;
    int k;
    r = '0;
    case (act)
      mrrim_pkg::ACT_START: begin
        req[0] = m_slave; req[1] = mrrim_pkg::FUNC_READ_INPUT;
        req[2] = d[15:8]; req[3] = d[7:0]; req[4] = 8'h00; req[5] = d[23:16];
        c = mrrim_pkg::CRC_INIT;
        for (k = 0; k < 6; k++) c = crc_next(c, req[k]);
        req[6] = c[7:0]; req[7] = c[15:8];
        for (k = 0; k < 8; k++) begin
          r = '0; r.kind = mrrim_pkg::KIND_TX; r.tx_data = req[k]; r.last = (k == 7);
          sb.note_input(r);
        end
        m_receiving = 1'b1; m_rx_count = 0; m_remaining = 9; m_crc = mrrim_pkg::CRC_INIT;
        m_func = 0; m_byte_count = 0; m_high = 0; m_ticks = 0; m_slave_bad = 0;
        for (k = 0; k < DEPTH; k++) staged_words[k] = store_words[k];
      end
      mrrim_pkg::ACT_BYTE: begin
        b = d[31:24];
        n = m_rx_count;
        if (!m_receiving || (n == 0 && b == 0)) return;
        m_crc = crc_next(m_crc, b);
        if (m_rx_count != 8'hFF) m_rx_count++;
        case (n)
          0: m_slave_bad = (b != m_slave);
          1: m_func = b;
          2: m_byte_count = b;
          3: m_high = b;
          4: begin
            if (m_slave_bad)
              sb.note_input(status_word(mrrim_pkg::ST_BAD_SLAVE, 8'h00, 7'd0));
            else if ((m_func & mrrim_pkg::FUNC_MASK) != mrrim_pkg::FUNC_READ_INPUT)
              sb.note_input(status_word(mrrim_pkg::ST_BAD_FUNC, 8'h00, 7'd0));
            else if (m_func[7])
              sb.note_input(status_word(mrrim_pkg::ST_EXCEPTION, m_byte_count, 7'd0));
            else begin
              stage(0, b);
              m_remaining = m_byte_count;
              if (m_remaining == 0) close_reply();
            end
          end
          default: begin
            if (m_remaining == 0) return;
            k = m_byte_count + 2 - m_remaining;
            if (k & 1) stage(k >> 1, b);
            else m_high = b;
            m_remaining--;
            if (m_remaining == 0) close_reply();
          end
        endcase
      end
      mrrim_pkg::ACT_TICK: begin
        if (!m_receiving) return;
        if (m_ticks >= m_timeout)
          sb.note_input(status_word(mrrim_pkg::ST_TIMEOUT, 8'h00, 7'd0));
        else m_ticks++;
      end
      default: begin
        r.kind = mrrim_pkg::KIND_READ;
        r.read_value = d[39:32] < DEPTH ? store_words[d[39:32]]
                                        : mrrim_pkg::READ_OOB_VALUE;
        sb.note_input(r);
      end
    endcase
  endfunction

  // Sends one input word and waits for it to be accepted; valid stays high
  // into the next word unless the sender idles.
  task automatic send_word(logic [1:0] act, logic [39:0] d);
    while (!no_idle && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_master(act, d);
    @(negedge clk_i);
  endtask

  task automatic send_start(logic [15:0] reg_addr, logic [7:0] qty);
    send_word(mrrim_pkg::ACT_START, {16'h0, qty, reg_addr});
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(mrrim_pkg::ACT_BYTE, {8'h0, b, 24'h0});
  endtask

  task automatic send_read(logic [7:0] idx);
    send_word(mrrim_pkg::ACT_READ, {idx, 32'h0});
  endtask

  // Sends a reply frame; corrupt flips the CRC.
  task automatic send_reply(logic [7:0] slave, logic [7:0] func, int nbytes,
                            bit corrupt, int lead_zeros);
    logic [7:0] frame [$];
    logic [15:0] c;
    frame.push_back(slave);
    frame.push_back(func);
    frame.push_back(nbytes[7:0]);
    for (int i = 0; i < nbytes; i++) frame.push_back(8'($urandom_range(255)));
    c = mrrim_pkg::CRC_INIT;
    foreach (frame[i]) c = crc_next(c, frame[i]);
    if (corrupt) c ^= 16'h0001 << $urandom_range(15);
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    repeat (lead_zeros) send_byte(8'h00);
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mrrim_pkg::CFG_SLAVE_ADDRESS) m_slave = v[7:0];
    else m_timeout = v;
  endtask

  // Reads a random word that some accepted reply has written, or past the store.
  task automatic read_safe();
    int idx;
    idx = $urandom_range(DEPTH - 1);
    if ($urandom_range(3) == 0) begin
      send_read(8'($urandom_range(255, DEPTH)));
      return;
    end
    for (int t = 0; t < DEPTH; t++)
      if (store_written[(idx + t) % DEPTH]) begin
        send_read(8'((idx + t) % DEPTH));
        return;
      end
    send_read(8'hFF);
  endtask

  // Result side: random stalls, checks each accepted word.
  always @(negedge clk_i)
    m_axis_tready <= no_idle || !idle_rx || ($urandom_range(99) >= 22);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result('{m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[10:8],
                        m_axis_tdata[18:11], m_axis_tdata[25:19], m_axis_tdata[41:26]});

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int sel, nb;
    m_receiving = 0; m_rx_count = 0; m_remaining = 0; m_crc = mrrim_pkg::CRC_INIT;
    m_func = 0; m_byte_count = 0; m_high = 0; m_ticks = 0; m_slave_bad = 0;
    for (int i = 0; i < DEPTH; i++) begin
      store_words[i] = 0; staged_words[i] = 0; store_written[i] = 0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    send_byte(8'h55);
    send_word(mrrim_pkg::ACT_TICK, '0);
    send_read(8'd64);
    send_read(8'hFF);
    send_start(16'hFFFF, 8'hFF);
    send_reply(8'h01, mrrim_pkg::FUNC_READ_INPUT, 4, 0, 2);
    send_read(8'd0);
    send_read(8'd1);
    send_start(16'h0000, 8'h00);
    send_reply(8'h01, mrrim_pkg::FUNC_READ_INPUT, 0, 0, 0);
    send_start(16'h1234, 8'h7F);
    send_reply(8'h01, mrrim_pkg::FUNC_READ_INPUT, 3, 0, 0);
    send_start(16'h8001, 8'd3);
    send_reply(8'h01, mrrim_pkg::FUNC_READ_INPUT, 2, 1, 0);
    send_start(16'h0001, 8'd1);
    send_byte(8'h01); send_byte(8'h84); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hAA);
    send_start(16'h0002, 8'd1);
    send_byte(8'h01); send_byte(8'h84); send_byte(8'h02); send_byte(8'h00); send_byte(8'h00);
    send_start(16'h0003, 8'd1);
    send_byte(8'h02); send_byte(8'h04); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_start(16'h0004, 8'd1);
    send_byte(8'h01); send_byte(8'h03); send_byte(8'h02); send_byte(8'h00); send_byte(8'h00);
    send_start(16'h0005, 8'd1);
    send_byte(8'h01);
    send_start(16'h0006, 8'd2);
    send_reply(8'h01, mrrim_pkg::FUNC_READ_INPUT, 130, 0, 0);
    send_read(8'd63);

    // Timeout with a limit of one tick, then a stretch at the longest.
    write_cfg(mrrim_pkg::CFG_TIMEOUT_TICKS, 16'd1);
    send_start(16'h0007, 8'd1);
    repeat (3) send_word(mrrim_pkg::ACT_TICK, '0);
    write_cfg(mrrim_pkg::CFG_SLAVE_ADDRESS, 16'd255);
    write_cfg(mrrim_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);

    // Random part, in three settings; the middle one runs without idling.
    for (int phs = 0; phs < 3; phs++) begin
      no_idle = (phs == 1);
      if (phs == 1) write_cfg(mrrim_pkg::CFG_SLAVE_ADDRESS, 16'd1);
      if (phs == 2) begin
        write_cfg(mrrim_pkg::CFG_SLAVE_ADDRESS, 16'($urandom_range(255, 1)));
        write_cfg(mrrim_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(8, 1)));
      end
      for (int it = 0; it < ((phs == 1) ? 4 : 2); it++) begin
        if (it == 1) wait_drained();
        sel = $urandom_range(99);
        nb = $urandom_range(6);
        send_start(16'($urandom), 8'($urandom));
        if (sel < 60)
          send_reply(m_slave, mrrim_pkg::FUNC_READ_INPUT, nb, $urandom_range(9) == 0,
                     $urandom_range(2));
        else if (sel < 70) begin
          send_byte(m_slave); send_byte(8'h84); send_byte(8'($urandom));
          send_byte(8'($urandom)); send_byte(8'($urandom));
        end else if (sel < 80)
          send_reply(8'($urandom), 8'($urandom), $urandom_range(6), 0, 0);
        else if (sel < 90)
          repeat ($urandom_range(12)) send_word(mrrim_pkg::ACT_TICK, '0);
        else
          repeat ($urandom_range(9)) send_byte(8'($urandom));
        repeat ($urandom_range(3)) read_safe();
      end
    end
    no_idle = 0;

    wait_drained();
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
